FILE: hdl/lvdtqpd_pkg.sv
// lvdtqpd_pkg: shared constants for the lvdt quadrature phase difference block
// holds default widths, block length and output field width
// no dependencies
package lvdtqpd_pkg;

	// default ADC sample width
	localparam int SAMPLE_BITS_DEF = 12;
	// default binary angle width, pi = 2^(ANGLE_BITS-1)
	localparam int ANGLE_BITS_DEF = 16;
	// samples per quadrature block, fixed by the four-point scheme
	localparam int BLOCK_SAMPLES = 4;
	// width of each phase field on the output stream
	localparam int OUT_BITS = 16;

endpackage

FILE: hdl/lvdt_quadrature_phase_difference.sv
// lvdt_quadrature_phase_difference: two-channel four-point phase detector with a
// serial compare-subtract divider for the ratio atan2 approximation
// depends on lvdtqpd_pkg
//
// Usage:
// s_* carries ADC samples, s_tuser selects the coil (0 channel A, 1 channel B) and
// s_tdata holds the raw sample. cfg_* writes the enable bit; while it is 0 every
// sample transaction is taken and dropped. Each channel gathers four samples and
// turns them into a binary angle (pi = 2^(ANGLE_BITS-1)). Once both channels hold
// a fresh angle, one result goes out on m_*: A minus B wrapped to [-pi, pi),
// followed by the A and B angles.
// Timing: a sample that does not complete a block is taken without dropping s_tready. A sample
// that completes a block keeps s_tready low through the setup states (ST_ABS,
// ST_RATIO), ANGLE_BITS-2 divider steps and the finish state, the steps run by the
// single compare-subtract unit that produces one quotient bit per cycle. With
// both differences zero the divider is skipped and s_tready is low through the
// setup and finish states only. A result appears on m_tvalid in the cycle after
// the finish. The output register frees the input side: new samples are taken
// while a result waits. If a new result is ready while the previous one is still
// stalled by m_tready, the block holds in its finish cycle until the slot clears.
// Reset clears the enable bit, fill counts, angles, fresh flags and the output
// valid; sample buffers are not cleared and are always written before use.
module lvdt_quadrature_phase_difference #(
	parameter int SAMPLE_BITS = lvdtqpd_pkg::SAMPLE_BITS_DEF,
	parameter int ANGLE_BITS  = lvdtqpd_pkg::ANGLE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration write channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic                                    cfg_data,     // enable
	// sample stream in
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,      // sample
	input  logic                                    s_tuser,      // channel
	// phase stream out
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [3*lvdtqpd_pkg::OUT_BITS-1:0]      m_tdata       // phase_difference, phase_a, phase_b
);
	import lvdtqpd_pkg::*;

	localparam int CountBits = $clog2(BLOCK_SAMPLES);
	localparam int StepCount = ANGLE_BITS - 2;
	localparam int StepBits  = $clog2(StepCount);
	localparam int RemBits   = SAMPLE_BITS + 1;
	localparam int WideBits  = (ANGLE_BITS > OUT_BITS) ? ANGLE_BITS : OUT_BITS;
	localparam logic [ANGLE_BITS-1:0] QuarterPi      = ANGLE_BITS'(1) << (ANGLE_BITS - 3);
	localparam logic [ANGLE_BITS-1:0] ThreeQuarterPi = ANGLE_BITS'(3) << (ANGLE_BITS - 3);
	localparam logic [StepBits-1:0]   LastStep       = StepBits'(StepCount - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABS,
		ST_RATIO,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic                    enable_q;
	logic [CountBits-1:0]    count_a_q;
	logic [CountBits-1:0]    count_b_q;
	logic [SAMPLE_BITS-1:0]  buf_a_q [BLOCK_SAMPLES];
	logic [SAMPLE_BITS-1:0]  buf_b_q [BLOCK_SAMPLES];
	logic                    chan_q;
	logic [SAMPLE_BITS-1:0]  ax_q;
	logic [SAMPLE_BITS-1:0]  ay_q;
	logic                    x_neg_q;
	logic                    y_neg_q;
	logic                    zero_q;
	logic                    num_neg_q;
	logic [RemBits-1:0]      den_q;
	logic [RemBits-1:0]      rem_q;
	logic [StepCount-1:0]    quot_q;
	logic [StepBits-1:0]     step_q;
	logic [ANGLE_BITS-1:0]   angle_a_q;
	logic [ANGLE_BITS-1:0]   angle_b_q;
	logic                    fresh_a_q;
	logic                    fresh_b_q;
	logic                    m_tvalid_q;
	logic [3*OUT_BITS-1:0]   m_tdata_q;

	logic                    take;
	logic [SAMPLE_BITS-1:0]  sample;
	logic [SAMPLE_BITS-1:0]  s0, s1, s2, s3;
	logic [SAMPLE_BITS:0]    i_diff;
	logic [SAMPLE_BITS:0]    q_diff;
	logic [SAMPLE_BITS:0]    i_abs;
	logic [SAMPLE_BITS:0]    q_abs;
	logic [SAMPLE_BITS:0]    mag_diff;
	logic [SAMPLE_BITS:0]    mag_abs;
	logic                    mag_nz;
	logic [RemBits:0]        cand;
	logic                    fits;
	logic [RemBits:0]        cand_sub;
	logic [ANGLE_BITS-1:0]   base;
	logic [ANGLE_BITS-1:0]   quot_ext;
	logic [ANGLE_BITS-1:0]   ang_pos;
	logic [ANGLE_BITS-1:0]   ang;
	logic [ANGLE_BITS-1:0]   ang_a_new;
	logic [ANGLE_BITS-1:0]   ang_b_new;
	logic [ANGLE_BITS-1:0]   ang_diff;
	logic                    other_fresh;
	logic                    out_free;
	logic [WideBits-1:0]     diff_wide;
	logic [WideBits-1:0]     a_wide;
	logic [WideBits-1:0]     b_wide;

	// handshakes
	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign take      = s_tvalid && s_tready && enable_q;
	assign sample    = s_tdata[SAMPLE_BITS-1:0];
	assign out_free  = !m_tvalid_q || m_tready;

	// block samples of the channel being solved
	assign s0 = chan_q ? buf_b_q[0] : buf_a_q[0];
	assign s1 = chan_q ? buf_b_q[1] : buf_a_q[1];
	assign s2 = chan_q ? buf_b_q[2] : buf_a_q[2];
	assign s3 = chan_q ? buf_b_q[3] : buf_a_q[3];

	// in-phase and quadrature differences and their magnitudes
	assign i_diff = {1'b0, s0} - {1'b0, s2};
	assign q_diff = {1'b0, s1} - {1'b0, s3};
	assign i_abs  = i_diff[SAMPLE_BITS] ? (~i_diff + 1'b1) : i_diff;
	assign q_abs  = q_diff[SAMPLE_BITS] ? (~q_diff + 1'b1) : q_diff;

	// numerator magnitude |ax - ay|, denominator is ax + ay
	assign mag_diff = {1'b0, ax_q} - {1'b0, ay_q};
	assign mag_abs  = mag_diff[SAMPLE_BITS] ? (~mag_diff + 1'b1) : mag_diff;
	assign mag_nz   = (mag_diff != '0);

	// shared compare-subtract step of the divider
	assign cand     = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign fits     = (cand >= {1'b0, den_q});
	assign cand_sub = cand - {1'b0, den_q};

	// angle from the quotient
	assign base     = x_neg_q ? ThreeQuarterPi : QuarterPi;
	assign quot_ext = ANGLE_BITS'(quot_q);
	assign ang_pos  = num_neg_q ? (base + quot_ext) : (base - quot_ext);
	assign ang      = zero_q ? '0 : (y_neg_q ? (~ang_pos + 1'b1) : ang_pos);

	// angles and difference as they stand after this block
	assign ang_a_new   = chan_q ? angle_a_q : ang;
	assign ang_b_new   = chan_q ? ang : angle_b_q;
	assign ang_diff    = ang_a_new - ang_b_new;
	assign other_fresh = chan_q ? fresh_a_q : fresh_b_q;
	assign diff_wide   = WideBits'(ang_diff);
	assign a_wide      = WideBits'(ang_a_new);
	assign b_wide      = WideBits'(ang_b_new);

	// sample buffers, written at the fill count
	always_ff @(posedge clk) begin
		if (take) begin
			if (s_tuser) begin
				buf_b_q[count_b_q] <= sample;
			end else begin
				buf_a_q[count_a_q] <= sample;
			end
		end
	end

	// sequencer, channel state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			enable_q   <= 1'b0;
			count_a_q  <= '0;
			count_b_q  <= '0;
			chan_q     <= 1'b0;
			ax_q       <= '0;
			ay_q       <= '0;
			x_neg_q    <= 1'b0;
			y_neg_q    <= 1'b0;
			zero_q     <= 1'b0;
			num_neg_q  <= 1'b0;
			den_q      <= '0;
			rem_q      <= '0;
			quot_q     <= '0;
			step_q     <= '0;
			angle_a_q  <= '0;
			angle_b_q  <= '0;
			fresh_a_q  <= 1'b0;
			fresh_b_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				enable_q <= cfg_data;
			end
			// a result leaving the finish cycle takes the slot over
			if (m_tvalid_q && m_tready && !((state_q == ST_DONE) && other_fresh)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						chan_q <= s_tuser;
						if (s_tuser) begin
							count_b_q <= count_b_q + 1'b1;
							if (count_b_q == CountBits'(BLOCK_SAMPLES - 1)) begin
								state_q <= ST_ABS;
							end
						end else begin
							count_a_q <= count_a_q + 1'b1;
							if (count_a_q == CountBits'(BLOCK_SAMPLES - 1)) begin
								state_q <= ST_ABS;
							end
						end
					end
				end
				ST_ABS: begin
					ax_q    <= q_abs[SAMPLE_BITS-1:0];
					ay_q    <= i_abs[SAMPLE_BITS-1:0];
					x_neg_q <= q_diff[SAMPLE_BITS];
					y_neg_q <= i_diff[SAMPLE_BITS];
					state_q <= ST_RATIO;
				end
				ST_RATIO: begin
					den_q     <= {1'b0, ax_q} + {1'b0, ay_q};
					rem_q     <= mag_abs;
					num_neg_q <= x_neg_q ? (!mag_diff[SAMPLE_BITS] && mag_nz)
						: mag_diff[SAMPLE_BITS];
					zero_q    <= (ax_q == '0) && (ay_q == '0);
					quot_q    <= '0;
					step_q    <= '0;
					state_q   <= ((ax_q == '0) && (ay_q == '0)) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= fits ? cand_sub[RemBits-1:0] : cand[RemBits-1:0];
					quot_q <= {quot_q[StepCount-2:0], fits};
					step_q <= step_q + 1'b1;
					if (step_q == LastStep) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!other_fresh || out_free) begin
						angle_a_q <= ang_a_new;
						angle_b_q <= ang_b_new;
						state_q   <= ST_IDLE;
						if (other_fresh) begin
							fresh_a_q  <= 1'b0;
							fresh_b_q  <= 1'b0;
							m_tvalid_q <= 1'b1;
							m_tdata_q  <= {b_wide[OUT_BITS-1:0], a_wide[OUT_BITS-1:0],
								diff_wide[OUT_BITS-1:0]};
						end else if (chan_q) begin
							fresh_b_q <= 1'b1;
						end else begin
							fresh_a_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
